// ----- rtl/sdc_pkg.sv -----
// Shared constants and helpers for the stick distance constraint core.
// No dependencies.
package sdc_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int IDX_W = 16;

    // Start-to-strobe latency in cycles for a given coordinate width.
    // Three front stages, root pipe, three middle stages, divider pipe, output register.
    function automatic int latency(input int w);
        latency = 2 * w + 9;
    endfunction

endpackage

// ----- rtl/stick_distance_constraint_core.sv -----
// Stick distance constraint core: moves two vertices so their distance equals the rest length.
// Depends on sdc_pkg, sdc_sqrt, sdc_div.
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------------
//  input    | start, busy          | first/second_index, first/second_x/y, rest_length
//  result   | result_valid strobe  | *_index_out, new_first/second_x/y, degenerate
//
// One transaction enters per cycle; busy stays low. Each result passes through the front stages,
// the bit-per-stage root pipe, the middle stages, the divider pipe and the output register.
// Reset clears only the valid bits of the stages; nothing is in flight afterwards.
// The receiver cannot stall, so the pipeline never holds.
module stick_distance_constraint_core #(
    parameter int COORD_WIDTH = sdc_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [sdc_pkg::IDX_W-1:0]     first_index,
    input  logic [sdc_pkg::IDX_W-1:0]     second_index,
    input  logic signed [COORD_WIDTH-1:0] first_x,
    input  logic signed [COORD_WIDTH-1:0] first_y,
    input  logic signed [COORD_WIDTH-1:0] second_x,
    input  logic signed [COORD_WIDTH-1:0] second_y,
    input  logic [COORD_WIDTH-2:0]        rest_length,
    output logic                          result_valid,
    output logic [sdc_pkg::IDX_W-1:0]     first_index_out,
    output logic [sdc_pkg::IDX_W-1:0]     second_index_out,
    output logic signed [COORD_WIDTH-1:0] new_first_x,
    output logic signed [COORD_WIDTH-1:0] new_first_y,
    output logic signed [COORD_WIDTH-1:0] new_second_x,
    output logic signed [COORD_WIDTH-1:0] new_second_y,
    output logic                          degenerate
);

    localparam int W   = COORD_WIDTH;
    localparam int IW  = sdc_pkg::IDX_W;
    localparam int DW  = W + 1;        // signed difference
    localparam int MW  = W + 1;        // its magnitude
    localparam int SW  = 2 * MW;       // squares and their sum
    localparam int RW  = W + 1;        // root, length error
    localparam int PW  = MW + RW;      // |d| * |err|
    localparam int NW  = 2 * W + 3;    // numerator
    localparam int DVW = RW + 1;       // 2 * dist
    localparam int QW  = W + 1;        // correction magnitude
    localparam int FW  = W + 3;        // corrected coordinate before saturation

    localparam logic signed [FW-1:0] MAXV = {4'b0000, {(W-1){1'b1}}};
    localparam logic signed [FW-1:0] MINV = {4'b1111, {(W-1){1'b0}}};

    typedef struct packed {
        logic [IW-1:0]       idx1;
        logic [IW-1:0]       idx2;
        logic signed [W-1:0] x1;
        logic signed [W-1:0] y1;
        logic signed [W-1:0] x2;
        logic signed [W-1:0] y2;
        logic [W-2:0]        rest;
        logic [MW-1:0]       mdx;
        logic [MW-1:0]       mdy;
        logic                sdx;
        logic                sdy;
        logic                deg;
    } item_t;

    typedef struct packed {
        logic [IW-1:0]       idx1;
        logic [IW-1:0]       idx2;
        logic signed [W-1:0] x1;
        logic signed [W-1:0] x2;
        logic                neg;
        logic                deg;
    } xtag_t;

    typedef struct packed {
        logic signed [W-1:0] y1;
        logic signed [W-1:0] y2;
        logic                neg;
    } ytag_t;

    function automatic logic signed [W-1:0] sat(input logic signed [FW-1:0] v);
        if (v > MAXV)
            sat = MAXV[W-1:0];
        else if (v < MINV)
            sat = MINV[W-1:0];
        else
            sat = v[W-1:0];
    endfunction

    logic accept;
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // stage 1: capture and differences
    logic                 s1_valid_reg;
    logic [IW-1:0]        s1_idx1_reg, s1_idx2_reg;
    logic signed [W-1:0]  s1_x1_reg, s1_y1_reg, s1_x2_reg, s1_y2_reg;
    logic [W-2:0]         s1_rest_reg;
    logic signed [DW-1:0] s1_dx_reg, s1_dy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        s1_idx1_reg <= first_index;
        s1_idx2_reg <= second_index;
        s1_x1_reg   <= first_x;
        s1_y1_reg   <= first_y;
        s1_x2_reg   <= second_x;
        s1_y2_reg   <= second_y;
        s1_rest_reg <= rest_length;
        s1_dx_reg   <= DW'(first_x) - DW'(second_x);
        s1_dy_reg   <= DW'(first_y) - DW'(second_y);
    end

    // stage 2: magnitudes and squares
    logic [MW-1:0] mdx_next, mdy_next;
    assign mdx_next = s1_dx_reg[DW-1] ? MW'(-s1_dx_reg) : MW'(s1_dx_reg);
    assign mdy_next = s1_dy_reg[DW-1] ? MW'(-s1_dy_reg) : MW'(s1_dy_reg);

    logic          s2_valid_reg;
    item_t         s2_item_reg;
    logic [SW-1:0] s2_sqx_reg, s2_sqy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_item_reg.idx1 <= s1_idx1_reg;
        s2_item_reg.idx2 <= s1_idx2_reg;
        s2_item_reg.x1   <= s1_x1_reg;
        s2_item_reg.y1   <= s1_y1_reg;
        s2_item_reg.x2   <= s1_x2_reg;
        s2_item_reg.y2   <= s1_y2_reg;
        s2_item_reg.rest <= s1_rest_reg;
        s2_item_reg.mdx  <= mdx_next;
        s2_item_reg.mdy  <= mdy_next;
        s2_item_reg.sdx  <= s1_dx_reg[DW-1];
        s2_item_reg.sdy  <= s1_dy_reg[DW-1];
        s2_item_reg.deg  <= (s1_dx_reg == '0) && (s1_dy_reg == '0);
        s2_sqx_reg       <= SW'(mdx_next) * SW'(mdx_next);
        s2_sqy_reg       <= SW'(mdy_next) * SW'(mdy_next);
    end

    // stage 3: sum of squares into the root pipe
    logic          s3_valid_reg;
    item_t         s3_item_reg;
    logic [SW-1:0] s3_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s3_item_reg <= s2_item_reg;
        s3_sum_reg  <= s2_sqx_reg + s2_sqy_reg;
    end

    logic                 sq_valid;
    logic [RW-1:0]        sq_root;
    logic [$bits(item_t)-1:0] sq_tag;
    item_t                sq_item;

    sdc_sqrt #(
        .RW    (RW),
        .TAG_W ($bits(item_t))
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid_reg),
        .in_rad    (s3_sum_reg),
        .in_tag    (s3_item_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_tag   (sq_tag)
    );

    assign sq_item = item_t'(sq_tag);

    // stage 4: length error
    logic          s4_valid_reg;
    item_t         s4_item_reg;
    logic [RW-1:0] s4_dist_reg, s4_uerr_reg;
    logic          s4_eneg_reg;
    logic          eneg_next;

    assign eneg_next = sq_root > RW'(sq_item.rest);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else
            s4_valid_reg <= sq_valid;
    end

    always_ff @(posedge clk)
    begin
        s4_item_reg <= sq_item;
        s4_dist_reg <= sq_root;
        s4_eneg_reg <= eneg_next;
        s4_uerr_reg <= eneg_next ? sq_root - RW'(sq_item.rest) : RW'(sq_item.rest) - sq_root;
    end

    // stage 5: |d| * |err|
    logic               s5_valid_reg;
    item_t              s5_item_reg;
    logic [RW-1:0]      s5_dist_reg;
    logic               s5_eneg_reg;
    logic [PW-1:0]      s5_px_reg, s5_py_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_valid_reg <= 1'b0;
        else
            s5_valid_reg <= s4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s5_item_reg <= s4_item_reg;
        s5_dist_reg <= s4_dist_reg;
        s5_eneg_reg <= s4_eneg_reg;
        s5_px_reg   <= PW'(s4_item_reg.mdx) * PW'(s4_uerr_reg);
        s5_py_reg   <= PW'(s4_item_reg.mdy) * PW'(s4_uerr_reg);
    end

    // stage 6: rounding offset and divisor
    logic           s6_valid_reg;
    logic [NW-1:0]  s6_numx_reg, s6_numy_reg;
    logic [DVW-1:0] s6_den_reg;
    xtag_t          s6_xtag_reg;
    ytag_t          s6_ytag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s6_valid_reg <= 1'b0;
        else
            s6_valid_reg <= s5_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s6_numx_reg      <= NW'(s5_px_reg) + NW'(s5_dist_reg);
        s6_numy_reg      <= NW'(s5_py_reg) + NW'(s5_dist_reg);
        s6_den_reg       <= {s5_dist_reg, 1'b0};
        s6_xtag_reg.idx1 <= s5_item_reg.idx1;
        s6_xtag_reg.idx2 <= s5_item_reg.idx2;
        s6_xtag_reg.x1   <= s5_item_reg.x1;
        s6_xtag_reg.x2   <= s5_item_reg.x2;
        s6_xtag_reg.neg  <= s5_item_reg.sdx ^ s5_eneg_reg;
        s6_xtag_reg.deg  <= s5_item_reg.deg;
        s6_ytag_reg.y1   <= s5_item_reg.y1;
        s6_ytag_reg.y2   <= s5_item_reg.y2;
        s6_ytag_reg.neg  <= s5_item_reg.sdy ^ s5_eneg_reg;
    end

    // divider pipes; coincident points divide by zero here and are overridden below
    logic                     dx_valid, dy_valid;
    logic [QW-1:0]            qx, qy;
    logic [$bits(xtag_t)-1:0] dx_tag;
    logic [$bits(ytag_t)-1:0] dy_tag;
    xtag_t                    xt;
    ytag_t                    yt;

    sdc_div #(
        .NW    (NW),
        .DVW   (DVW),
        .QW    (QW),
        .TAG_W ($bits(xtag_t))
    ) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s6_valid_reg),
        .in_num    (s6_numx_reg),
        .in_den    (s6_den_reg),
        .in_tag    (s6_xtag_reg),
        .out_valid (dx_valid),
        .out_quo   (qx),
        .out_tag   (dx_tag)
    );

    sdc_div #(
        .NW    (NW),
        .DVW   (DVW),
        .QW    (QW),
        .TAG_W ($bits(ytag_t))
    ) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s6_valid_reg),
        .in_num    (s6_numy_reg),
        .in_den    (s6_den_reg),
        .in_tag    (s6_ytag_reg),
        .out_valid (dy_valid),
        .out_quo   (qy),
        .out_tag   (dy_tag)
    );

    assign xt = xtag_t'(dx_tag);
    assign yt = ytag_t'(dy_tag);

    // output stage: apply signed correction and saturate, or pass coincident points unchanged
    logic signed [FW-1:0] cx, cy;
    logic signed [FW-1:0] fx, fy, sx, sy;

    assign cx = xt.neg ? -FW'({1'b0, qx}) : FW'({1'b0, qx});
    assign cy = yt.neg ? -FW'({1'b0, qy}) : FW'({1'b0, qy});
    assign fx = FW'(xt.x1) + cx;
    assign sx = FW'(xt.x2) - cx;
    assign fy = FW'(yt.y1) + cy;
    assign sy = FW'(yt.y2) - cy;

    logic                result_valid_reg;
    logic [IW-1:0]       idx1_out_reg, idx2_out_reg;
    logic signed [W-1:0] nfx_reg, nfy_reg, nsx_reg, nsy_reg;
    logic                deg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= dx_valid & dy_valid;
    end

    always_ff @(posedge clk)
    begin
        idx1_out_reg <= xt.idx1;
        idx2_out_reg <= xt.idx2;
        deg_reg      <= xt.deg;
        nfx_reg      <= xt.deg ? xt.x1 : sat(fx);
        nsx_reg      <= xt.deg ? xt.x2 : sat(sx);
        nfy_reg      <= xt.deg ? yt.y1 : sat(fy);
        nsy_reg      <= xt.deg ? yt.y2 : sat(sy);
    end

    assign result_valid     = result_valid_reg;
    assign first_index_out  = idx1_out_reg;
    assign second_index_out = idx2_out_reg;
    assign new_first_x      = nfx_reg;
    assign new_first_y      = nfy_reg;
    assign new_second_x     = nsx_reg;
    assign new_second_y     = nsy_reg;
    assign degenerate       = deg_reg;

endmodule

// ----- rtl/sdc_sqrt.sv -----
// Pipelined integer square root, one result bit per stage, with a tag carried alongside.
// Standalone; used by stick_distance_constraint_core.
module sdc_sqrt #(
    parameter int RW    = 25,
    parameter int TAG_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [2*RW-1:0]   in_rad,
    input  logic [TAG_W-1:0]  in_tag,
    output logic              out_valid,
    output logic [RW-1:0]     out_root,
    output logic [TAG_W-1:0]  out_tag
);

    localparam int SW = 2 * RW;

    logic [SW-1:0]    op_reg  [RW];
    logic [SW-1:0]    res_reg [RW];
    logic [TAG_W-1:0] tag_reg [RW];
    logic [RW-1:0]    valid_reg;

    for (genvar i = 0; i < RW; i++) begin : g_stage
        localparam logic [SW-1:0] ONE = SW'(1) << (2 * (RW - 1 - i));
        logic [SW-1:0]    op_in;
        logic [SW-1:0]    res_in;
        logic [TAG_W-1:0] tag_in;
        logic             v_in;
        logic [SW-1:0]    trial;
        logic [SW-1:0]    op_next;
        logic [SW-1:0]    res_next;

        if (i == 0) begin : g_first
            assign op_in  = in_rad;
            assign res_in = '0;
            assign tag_in = in_tag;
            assign v_in   = in_valid;
        end else begin : g_rest
            assign op_in  = op_reg[i-1];
            assign res_in = res_reg[i-1];
            assign tag_in = tag_reg[i-1];
            assign v_in   = valid_reg[i-1];
        end

        assign trial = res_in + ONE;

        always_comb
        begin
            if (op_in >= trial)
            begin
                op_next  = op_in - trial;
                res_next = (res_in >> 1) + ONE;
            end
            else
            begin
                op_next  = op_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else
                valid_reg[i] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            op_reg[i]  <= op_next;
            res_reg[i] <= res_next;
            tag_reg[i] <= tag_in;
        end
    end

    assign out_valid = valid_reg[RW-1];
    assign out_root  = res_reg[RW-1][RW-1:0];
    assign out_tag   = tag_reg[RW-1];

endmodule

// ----- rtl/sdc_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with a tag carried alongside.
// Standalone; quotient must fit in QW bits. Used by stick_distance_constraint_core.
module sdc_div #(
    parameter int NW    = 51,
    parameter int DVW   = 26,
    parameter int QW    = 25,
    parameter int TAG_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [NW-1:0]     in_num,
    input  logic [DVW-1:0]    in_den,
    input  logic [TAG_W-1:0]  in_tag,
    output logic              out_valid,
    output logic [QW-1:0]     out_quo,
    output logic [TAG_W-1:0]  out_tag
);

    localparam int XW = (NW > DVW + QW - 1) ? NW : DVW + QW - 1;

    logic [XW-1:0]    rem_reg [QW];
    logic [DVW-1:0]   den_reg [QW];
    logic [QW-1:0]    quo_reg [QW];
    logic [TAG_W-1:0] tag_reg [QW];
    logic [QW-1:0]    valid_reg;

    for (genvar i = 0; i < QW; i++) begin : g_stage
        localparam int SH = QW - 1 - i;
        logic [XW-1:0]    rem_in;
        logic [DVW-1:0]   den_in;
        logic [QW-1:0]    quo_in;
        logic [TAG_W-1:0] tag_in;
        logic             v_in;
        logic [XW-1:0]    cmp;
        logic [XW-1:0]    rem_next;
        logic [QW-1:0]    quo_next;

        if (i == 0) begin : g_first
            assign rem_in = XW'(in_num);
            assign den_in = in_den;
            assign quo_in = '0;
            assign tag_in = in_tag;
            assign v_in   = in_valid;
        end else begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign den_in = den_reg[i-1];
            assign quo_in = quo_reg[i-1];
            assign tag_in = tag_reg[i-1];
            assign v_in   = valid_reg[i-1];
        end

        assign cmp = XW'(den_in) << SH;

        always_comb
        begin
            if (rem_in >= cmp)
            begin
                rem_next = rem_in - cmp;
                quo_next = quo_in | (QW'(1) << SH);
            end
            else
            begin
                rem_next = rem_in;
                quo_next = quo_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else
                valid_reg[i] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i] <= rem_next;
            den_reg[i] <= den_in;
            quo_reg[i] <= quo_next;
            tag_reg[i] <= tag_in;
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign out_quo   = quo_reg[QW-1];
    assign out_tag   = tag_reg[QW-1];

endmodule

// ----- rtl/sdc_checker.sv -----
// Port-level checks for stick_distance_constraint_core, attached by bind.
// Depends on sdc_pkg.
module sdc_checker #(
    parameter int W = sdc_pkg::COORD_WIDTH_DEF
) (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic signed [W-1:0] first_x,
    input logic signed [W-1:0] first_y,
    input logic signed [W-1:0] second_x,
    input logic signed [W-1:0] second_y,
    input logic                result_valid,
    input logic signed [W-1:0] new_first_x,
    input logic signed [W-1:0] new_second_y,
    input logic                degenerate
);

    localparam int LAT = sdc_pkg::latency(W);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_start_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT result_valid)
        else $error("transaction lost");

    a_result_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy, LAT))
        else $error("result without transaction");

    a_degenerate_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (degenerate == $past(first_x == second_x && first_y == second_y, LAT)))
        else $error("degenerate flag wrong");

    a_degenerate_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && degenerate) |->
            (new_first_x == $past(first_x, LAT) && new_second_y == $past(second_y, LAT)))
        else $error("coincident points moved");

endmodule

bind stick_distance_constraint_core sdc_checker #(.W(COORD_WIDTH)) u_sdc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .first_x      (first_x),
    .first_y      (first_y),
    .second_x     (second_x),
    .second_y     (second_y),
    .result_valid (result_valid),
    .new_first_x  (new_first_x),
    .new_second_y (new_second_y),
    .degenerate   (degenerate)
);

// ----- test/tb_top.sv -----
// Testbench for stick_distance_constraint_core: directed and random stick transactions,
// checked against an in-bench predictor of the relaxation step.
// Depends on sdc_pkg and the core RTL.
module tb_top;

    localparam int CW       = sdc_pkg::COORD_WIDTH_DEF;
    localparam int RLW      = CW - 1;
    localparam int IW       = sdc_pkg::IDX_W;
    localparam int LAT      = sdc_pkg::latency(CW);
    localparam int MAX_CYC  = 200000;

    typedef struct {
        logic [IW-1:0]        i1;
        logic [IW-1:0]        i2;
        logic signed [CW-1:0] x1;
        logic signed [CW-1:0] y1;
        logic signed [CW-1:0] x2;
        logic signed [CW-1:0] y2;
        logic                 deg;
    } stick_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [IW-1:0]        first_index;
    logic [IW-1:0]        second_index;
    logic signed [CW-1:0] first_x;
    logic signed [CW-1:0] first_y;
    logic signed [CW-1:0] second_x;
    logic signed [CW-1:0] second_y;
    logic [CW-2:0]        rest_length;
    logic                 result_valid;
    logic [IW-1:0]        first_index_out;
    logic [IW-1:0]        second_index_out;
    logic signed [CW-1:0] new_first_x;
    logic signed [CW-1:0] new_first_y;
    logic signed [CW-1:0] new_second_x;
    logic signed [CW-1:0] new_second_y;
    logic                 degenerate;

    stick_t relaxed_q[$];
    int     errors = 0;
    int     cycles = 0;
    int     idle_pct = 0;

    stick_distance_constraint_core uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .first_index(first_index), .second_index(second_index),
        .first_x(first_x), .first_y(first_y),
        .second_x(second_x), .second_y(second_y),
        .rest_length(rest_length),
        .result_valid(result_valid),
        .first_index_out(first_index_out), .second_index_out(second_index_out),
        .new_first_x(new_first_x), .new_first_y(new_first_y),
        .new_second_x(new_second_x), .new_second_y(new_second_y),
        .degenerate(degenerate)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic signed [CW-1:0] clamp(input longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (CW - 1)) - 1;
        lo = -(longint'(1) <<< (CW - 1));
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v[CW-1:0];
    endfunction

    function automatic stick_t relax_stick(input logic [IW-1:0] i1, input logic [IW-1:0] i2,
                                           input logic signed [CW-1:0] ax,
                                           input logic signed [CW-1:0] ay,
                                           input logic signed [CW-1:0] bx,
                                           input logic signed [CW-1:0] by,
                                           input logic [CW-2:0] rest);
        stick_t r;
        longint dx, dy, cx, cy;
        longint unsigned ux, uy, sq, root, t, uerr, rl;
        bit err_neg;
        r.i1 = i1;
        r.i2 = i2;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        if (dx == 0 && dy == 0)
        begin
            r.x1 = ax; r.y1 = ay; r.x2 = bx; r.y2 = by; r.deg = 1'b1;
            return r;
        end
        ux = dx < 0 ? -dx : dx;
        uy = dy < 0 ? -dy : dy;
        sq = ux * ux + uy * uy;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            t = root | (64'd1 << b);
            if (t * t <= sq) root = t;
        end
        rl = rest;
        err_neg = root > rl;
        uerr = err_neg ? root - rl : rl - root;
        // adding dist before dividing by 2*dist rounds halves away from zero
        cx = (ux * uerr + root) / (2 * root);
        cy = (uy * uerr + root) / (2 * root);
        if ((dx < 0) != err_neg) cx = -cx;
        if ((dy < 0) != err_neg) cy = -cy;
        r.x1 = clamp(longint'(ax) + cx);
        r.y1 = clamp(longint'(ay) + cy);
        r.x2 = clamp(longint'(bx) - cx);
        r.y2 = clamp(longint'(by) - cy);
        r.deg = 1'b0;
        return r;
    endfunction

    // called at a rising edge; returns at the edge that accepts the transaction
    task automatic send_stick(input logic [IW-1:0] i1, input logic [IW-1:0] i2,
                              input logic signed [CW-1:0] ax, input logic signed [CW-1:0] ay,
                              input logic signed [CW-1:0] bx, input logic signed [CW-1:0] by,
                              input logic [CW-2:0] rest);
        int gap;
        if ($urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 4);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        first_index  <= i1;
        second_index <= i2;
        first_x      <= ax;
        first_y      <= ay;
        second_x     <= bx;
        second_y     <= by;
        rest_length  <= rest;
        @(posedge clk);
        while (busy) @(posedge clk);
        relaxed_q.push_back(relax_stick(i1, i2, ax, ay, bx, by, rest));
    endtask

    task automatic drain;
        start <= 1'b0;
        while (relaxed_q.size() != 0) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        stick_t e;
        if (rst_n && result_valid)
        begin
            if (relaxed_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result transaction", $time);
            end
            else
            begin
                e = relaxed_q.pop_front();
                if (first_index_out !== e.i1 || second_index_out !== e.i2 ||
                    new_first_x !== e.x1 || new_first_y !== e.y1 ||
                    new_second_x !== e.x2 || new_second_y !== e.y2 ||
                    degenerate !== e.deg)
                begin
                    errors++;
                    $display("%0t: mismatch exp idx %h %h p1 %0d,%0d p2 %0d,%0d deg %b",
                             $time, e.i1, e.i2, e.x1, e.y1, e.x2, e.y2, e.deg);
                    $display("%0t:          got idx %h %h p1 %0d,%0d p2 %0d,%0d deg %b",
                             $time, first_index_out, second_index_out, new_first_x,
                             new_first_y, new_second_x, new_second_y, degenerate);
                end
            end
        end
    end

    task automatic test_directed;
        localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
        localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
        localparam logic [CW-2:0]        RMAX = '1;
        idle_pct = 0;
        // coincident points, including extremes
        send_stick(16'h0000, 16'hffff, 24'sd100, -24'sd50, 24'sd100, -24'sd50, 23'd256);
        send_stick(16'hffff, 16'h0000, CMAX, CMIN, CMAX, CMIN, RMAX);
        send_stick(16'h1234, 16'h4321, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 23'd0);
        // axis-aligned and diagonal sticks, too long, too short and at rest length
        send_stick(16'd1, 16'd2, 24'sd2560, 24'sd0, 24'sd0, 24'sd0, 23'd1280);
        send_stick(16'd3, 16'd4, 24'sd0, 24'sd256, 24'sd0, -24'sd256, 23'd2048);
        send_stick(16'd5, 16'd6, -24'sd300, 24'sd0, 24'sd300, 24'sd0, 23'd600);
        send_stick(16'd7, 16'd8, 24'sd768, 24'sd1024, 24'sd0, 24'sd0, 23'd1280);
        // zero rest length and unit separations, odd halves
        send_stick(16'd9, 16'd10, 24'sd1, 24'sd0, 24'sd0, 24'sd0, 23'd0);
        send_stick(16'd11, 16'd12, 24'sd0, 24'sd1, 24'sd0, 24'sd0, 23'd2);
        send_stick(16'd13, 16'd14, 24'sd3, -24'sd7, -24'sd5, 24'sd2, 23'd0);
        send_stick(16'd15, 16'd16, -24'sd1, -24'sd1, 24'sd0, 24'sd0, 23'd3);
        // largest separations and saturation
        send_stick(16'haaaa, 16'h5555, CMAX, CMAX, CMIN, CMIN, 23'd0);
        send_stick(16'h5555, 16'haaaa, CMAX, CMAX, CMIN, CMIN, RMAX);
        send_stick(16'h8000, 16'h7fff, CMAX, 24'sd0, CMIN, 24'sd0, RMAX);
        send_stick(16'h7fff, 16'h8000, CMAX, 24'sd0, CMAX - 24'sd1, 24'sd0, RMAX);
        send_stick(16'h0f0f, 16'hf0f0, CMIN, CMIN, CMIN + 24'sd1, CMIN, RMAX);
        send_stick(16'h00ff, 16'hff00, 24'sd0, CMAX, 24'sd0, CMIN, RMAX);
        send_stick(16'h0001, 16'h8001, CMIN, 24'sd0, CMAX, 24'sd0, 23'd1);
        drain();
    endtask

    task automatic test_random(input int count, input int pct);
        logic signed [CW-1:0] ax, ay, bx, by;
        logic [CW-2:0] rest;
        int mode;
        idle_pct = pct;
        for (int n = 0; n < count; n++)
        begin
            mode = $urandom_range(0, 9);
            ax = CW'($urandom); ay = CW'($urandom); bx = CW'($urandom); by = CW'($urandom);
            rest = RLW'($urandom);
            if (mode >= 2 && mode <= 7)
            begin
                // short sticks with rest lengths of the same order
                bx = ax + $signed(24'($urandom_range(0, 8191)) - 24'sd4096);
                by = ay + $signed(24'($urandom_range(0, 8191)) - 24'sd4096);
                rest = RLW'($urandom_range(0, 6000));
            end
            else if (mode == 8)
            begin
                bx = ax; by = ay;
            end
            else if (mode == 9)
            begin
                ax = $urandom_range(0, 1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
                bx = -ax - 24'sd1 + $signed(24'($urandom_range(0, 2)));
            end
            send_stick(IW'($urandom), IW'($urandom), ax, ay, bx, by, rest);
            if (n == count / 2) drain();
        end
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        first_index = '0; second_index = '0;
        first_x = '0; first_y = '0; second_x = '0; second_y = '0;
        rest_length = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(430, 34);
        test_random(430, 65);
        test_random(440, 0);
        repeat (LAT + 10) @(posedge clk);
        if (errors == 0 && relaxed_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
